[rtl/core/median_filter_shrinking_edges_unit_macros.svh]
// assertion macros shared by the median filter checker
// needs clk and arst_n visible at the point of use
`ifndef MEDIAN_FILTER_SHRINKING_EDGES_UNIT_MACROS_SVH
`define MEDIAN_FILTER_SHRINKING_EDGES_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MFSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define MFSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mfse_pkg.sv]
// types and fixed constants for the median filter with shrinking edge windows
// no dependencies
package mfse_pkg;

	localparam int SAMPLE_W  = 16;  // sample and result width
	localparam int WS_W      = 4;   // window size register width
	localparam int WS_RESET  = 5;   // window size after reset
	localparam int POS_W     = 5;   // output position counter width
	localparam int POS_SAT   = 16;  // output position saturates here
	localparam int MAX_OUT   = 8;   // most results one input can release
	localparam int N_W       = 4;   // width of the per-input result counter

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_SCAN,
		ST_PUSH
	} state_t;

endpackage

[rtl/core/median_filter_shrinking_edges_unit.sv]
// median filter over a finite signed sample stream, shrinking windows at both ends
// uses mfse_pkg; rank search runs on one shared compare array under a small sequencer
//
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tlast | s_tdata: sample, s_tlast: final
//  out     | m_tvalid m_tready m_tdata m_tlast | m_tdata: filtered, m_tlast: final
//  cfg     | cfg_valid cfg_ready cfg_data     | cfg_data: window size
//
// an input is taken while the sequencer is idle; for each result it releases, the sequencer
// sets the window bounds, scans for the median and pushes it out; the rank search tests
// one candidate per cycle against the whole window in the shared compare array
// a result waits in the output register; the sequencer stalls only when it has a newer
// result and the register is still full
// arst_n clears counters, sequencer and output valid; sample storage needs no clearing
module median_filter_shrinking_edges_unit #(
	parameter int MAX_WINDOW = 15
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic signed [mfse_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
	input  logic                                  s_tlast,   // final sample
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic signed [mfse_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] filtered
	output logic                                  m_tlast,   // final output
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [mfse_pkg::WS_W-1:0]      cfg_data   // [3:0] window size
);
	import mfse_pkg::*;

	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int AW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	state_t state_q, state_d;

	logic        [WS_W-1:0]     ws_q;
	logic        [WS_W-1:0]     k_q;
	logic signed [SAMPLE_W-1:0] win_q [MAX_WINDOW];
	logic        [CNT_W-1:0]    lag_q;
	logic        [POS_W-1:0]    pos_q;
	logic                       fin_q;
	logic        [N_W-1:0]      n_q;
	logic        [IDX_W-1:0]    lo_q, hi_q, cand_q;
	logic        [CNT_W-1:0]    rank_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                       m_tvalid_q;
	logic signed [SAMPLE_W-1:0] m_tdata_q;
	logic                       m_tlast_q;

	logic [WS_W-1:0] k_eff;
	logic [AW-1:0]   half_w, ahead_w, pos_w, r_w, hi_w, cnt_w, lo_w;
	logic            emit_go;
	logic signed [SAMPLE_W-1:0] cand_val;
	logic [CNT_W-1:0] lt_cnt, le_cnt;
	logic            found;
	logic            accept, out_free, load_out;

	// effective window size from the register
	always_comb begin
		k_eff = (ws_q == '0) ? WS_W'(1) : ws_q;
		if (int'(k_eff) > MAX_WINDOW) begin
			k_eff = WS_W'(MAX_WINDOW);
		end
		if (int'(k_eff >> 1) * 2 + 1 > MAX_WINDOW) begin
			k_eff = k_eff - WS_W'(1);
		end
	end

	// window bounds for the next result
	always_comb begin
		half_w  = AW'(k_q >> 1);
		ahead_w = AW'(lag_q) - AW'(1);
		pos_w   = AW'(pos_q);
		r_w     = half_w;
		if (pos_w < r_w) begin
			r_w = pos_w;
		end
		if (ahead_w < r_w) begin
			r_w = ahead_w;
		end
		hi_w  = ahead_w + r_w;
		cnt_w = (r_w == half_w) ? AW'(k_q) : ((r_w << 1) + AW'(1));
		lo_w  = hi_w - cnt_w + AW'(1);
		emit_go = (n_q < N_W'(MAX_OUT)) &&
			(fin_q ? (lag_q != '0) : (AW'(lag_q) > half_w));
	end

	// shared compare array: rank of one candidate against the whole window
	always_comb begin
		cand_val = win_q[cand_q];
		lt_cnt   = '0;
		le_cnt   = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if ((IDX_W'(i) >= lo_q) && (IDX_W'(i) <= hi_q)) begin
				lt_cnt = lt_cnt + CNT_W'(win_q[i] <  cand_val);
				le_cnt = le_cnt + CNT_W'(win_q[i] <= cand_val);
			end
		end
		found = ((lt_cnt <= rank_q) && (le_cnt > rank_q)) || (cand_q == hi_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = emit_go ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (found) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (out_free) state_d = ST_EMIT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		accept    = s_tvalid && s_tready;
		out_free  = !m_tvalid_q || m_tready;
		load_out  = (state_q == ST_PUSH) && out_free;
		m_tvalid  = m_tvalid_q;
		m_tdata   = m_tdata_q;
		m_tlast   = m_tlast_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ws_q       <= WS_W'(WS_RESET);
			lag_q      <= '0;
			pos_q      <= '0;
			fin_q      <= 1'b0;
			n_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				ws_q <= cfg_data;
			end
			if (accept) begin
				fin_q <= s_tlast;
				n_q   <= '0;
				if (lag_q != CNT_W'(MAX_WINDOW)) lag_q <= lag_q + CNT_W'(1);
			end
			if ((state_q == ST_EMIT) && !emit_go && fin_q) begin
				lag_q <= '0;
				pos_q <= '0;
			end
			if (load_out) begin
				lag_q <= lag_q - CNT_W'(1);
				n_q   <= n_q + N_W'(1);
				if (pos_q != POS_W'(POS_SAT)) pos_q <= pos_q + POS_W'(1);
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// sample line, search registers and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q[0] <= s_tdata;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				win_q[i] <= win_q[i-1];
			end
			k_q <= k_eff;
		end
		if ((state_q == ST_EMIT) && emit_go) begin
			lo_q   <= IDX_W'(lo_w);
			hi_q   <= IDX_W'(hi_w);
			cand_q <= IDX_W'(lo_w);
			rank_q <= CNT_W'(cnt_w >> 1);
		end
		if (state_q == ST_SCAN) begin
			if (found) begin
				res_q <= cand_val;
			end else begin
				cand_q <= cand_q + IDX_W'(1);
			end
		end
		if (load_out) begin
			m_tdata_q <= res_q;
			m_tlast_q <= fin_q && (lag_q == CNT_W'(1));
		end
	end

endmodule

[rtl/core/mfse_checker.sv]
// port-level checks for the median filter, bound to the top level
// uses median_filter_shrinking_edges_unit_macros.svh
`include "median_filter_shrinking_edges_unit_macros.svh"

module mfse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result keeps its payload
	`MFSE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

	// the block works on one input transfer at a time
	`MFSE_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// a new result only appears while the sequencer is busy
	`MFSE_ASSERT_NOW(a_out_while_busy, $rose(m_tvalid), !s_tready, "result appeared while idle")

endmodule

bind median_filter_shrinking_edges_unit mfse_checker u_mfse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
